[rtl/tapq_pkg.sv]
package tapq_pkg;

    // Number of cells in the chain
    localparam int QUEUE_DEPTH = 16;

    // Field widths
    localparam int KEY_W = 32;
    localparam int IRQ_W = 9;
    localparam int OCC_W = 5;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // One queued action
    typedef struct packed {
        logic [KEY_W-1:0]        target;
        logic signed [IRQ_W-1:0] irq;
        logic                    action;
    } entry_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic   push;
        logic   pop;
        entry_t entry;
    } cell_ctrl_t;

endpackage

[rtl/tapq_cell.sv]
module tapq_cell
    import tapq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  entry_t     left_entry,
    input  logic       left_valid,
    input  logic       left_keep,
    input  entry_t     right_entry,
    input  logic       right_valid,
    output entry_t     entry,
    output logic       valid,
    output logic       keep
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   valid_reg;
    logic   valid_next;

    // Entry stays put on a push when it sorts ahead of (or ties with) the new key
    assign keep = valid_reg && (entry_reg.target <= ctrl.entry.target);

    // Next contents: hold, take new entry, shift from left, or shift from right
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctrl.pop)
        begin
            entry_next = right_entry;
            valid_next = right_valid;
        end
        else if (ctrl.push && !keep)
        begin
            if (left_keep)
            begin
                entry_next = ctrl.entry;
                valid_next = 1'b1;
            end
            else
            begin
                entry_next = left_entry;
                valid_next = left_valid;
            end
        end
    end

    // Payload register, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

    // Occupied cells form an unbroken run from the head
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> left_valid)
        else $error("tapq_cell: occupied cell behind an empty one");

endmodule

[rtl/timed_action_priority_queue.sv]
// Sorted queue of timed interrupt actions built as a chain of cells, head
// in the first cell. Raise start with opcode (0 push, 1 pop) and the entry
// fields while busy is low; every cell updates at that edge in parallel, and
// the transfer registers done, and the operation ends in one cycle with
// done high, during which busy is also high and the result is on the
// result ports. The next start can be taken the cycle after done. The
// receiver cannot stall; results must be captured in the done cycle. A
// push into a full queue and a pop of an empty queue return accepted low.
// An empty queue reports its head fields as all ones. Equal target counts
// leave in push order.
module timed_action_priority_queue
    import tapq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    opcode,
    input  logic                    action,
    input  logic signed [IRQ_W-1:0] irq_number,
    input  logic [KEY_W-1:0]        target_count,
    output logic                    done,
    output logic                    accepted,
    output logic                    head_valid,
    output logic [KEY_W-1:0]        head_target,
    output logic                    head_action,
    output logic signed [IRQ_W-1:0] head_irq,
    output logic [OCC_W-1:0]        occupancy
);

    logic             take;
    logic             push_ok;
    logic             pop_ok;
    cell_ctrl_t       ctrl;
    logic             done_reg;
    logic             accepted_reg;
    logic             accepted_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    entry_t           cell_entry [QUEUE_DEPTH];
    logic             cell_valid [QUEUE_DEPTH];
    logic             cell_keep  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] valid_vec;

    // Operation decode
    assign take    = start && !busy;
    assign push_ok = (opcode == OP_PUSH) && (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_ok  = (opcode == OP_POP) && (count_reg != '0);

    always_comb
    begin
        ctrl.push         = take && push_ok;
        ctrl.pop          = take && pop_ok;
        ctrl.entry.target = target_count;
        ctrl.entry.irq    = irq_number;
        ctrl.entry.action = action;
    end

    // Cell chain
    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            entry_t l_entry;
            logic   l_valid;
            logic   l_keep;
            entry_t r_entry;
            logic   r_valid;

            if (i == 0)
            begin : g_head
                assign l_entry = ctrl.entry;
                assign l_valid = 1'b1;
                assign l_keep  = 1'b1;
            end
            else
            begin : g_body
                assign l_entry = cell_entry[i-1];
                assign l_valid = cell_valid[i-1];
                assign l_keep  = cell_keep[i-1];
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_tail
                assign r_entry = ctrl.entry;
                assign r_valid = 1'b0;
            end
            else
            begin : g_mid
                assign r_entry = cell_entry[i+1];
                assign r_valid = cell_valid[i+1];
            end

            tapq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .left_entry  (l_entry),
                .left_valid  (l_valid),
                .left_keep   (l_keep),
                .right_entry (r_entry),
                .right_valid (r_valid),
                .entry       (cell_entry[i]),
                .valid       (cell_valid[i]),
                .keep        (cell_keep[i])
            );

            assign valid_vec[i] = cell_valid[i];
        end
    endgenerate

    // Occupancy counter and result status
    always_comb
    begin
        count_next    = count_reg;
        accepted_next = accepted_reg;
        if (take)
        begin
            accepted_next = push_ok || pop_ok;
            if (push_ok)
                count_next = count_reg + CNT_W'(1);
            else if (pop_ok)
                count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg     <= 1'b0;
            accepted_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            done_reg     <= take;
            accepted_reg <= accepted_next;
            count_reg    <= count_next;
        end
    end

    // Head result ports read the head cell directly
    assign busy        = done_reg;
    assign done        = done_reg;
    assign accepted    = accepted_reg;
    assign head_valid  = cell_valid[0];
    assign head_target = cell_valid[0] ? cell_entry[0].target : '1;
    assign head_action = cell_valid[0] ? cell_entry[0].action : 1'b1;
    assign head_irq    = cell_valid[0] ? cell_entry[0].irq : '1;
    assign occupancy   = OCC_W'(count_reg);

    // Counter tracks the occupied cells
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("tapq: count disagrees with occupied cells");

    // Every transfer yields exactly one result on the following cycle
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> done_reg)
        else $error("tapq: missing result after transfer");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("tapq: result repeated");

endmodule
